// File: rtl/alm_pkg.sv
// alm_pkg: shared types, constants and helper functions of the alarm clock menu controller.
// No dependencies; every other file of the block imports it.
package alm_pkg;

  localparam int NUM_ALARMS_DEF = 2;

  localparam int CMD_W    = 3;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int ZONE_W   = 7;
  localparam int MODE_W   = 4;
  localparam int SNZ_W    = 20;
  localparam int BEEP_W   = 16;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 20;

  localparam logic [HOUR_W-1:0] HOUR_TOP = HOUR_W'(23);
  localparam logic [MIN_W-1:0]  MIN_TOP  = MIN_W'(59);
  localparam int                ZONE_LIM = 48;
  localparam logic signed [ZONE_W-1:0] ZONE_RST = ZONE_W'(11);
  localparam logic [SNZ_W-1:0]  SNZ_MAX    = '1;
  localparam logic [SNZ_W-1:0]  SNOOZE_RST = SNZ_W'(120000);
  localparam logic [BEEP_W-1:0] BEEP_RST   = BEEP_W'(500);

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_RIGHT = 3'd1,
    CMD_LEFT  = 3'd2,
    CMD_UP    = 3'd3,
    CMD_DOWN  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SNOOZE = 2'd0,
    CFG_BEEP   = 2'd1
  } cfg_reg_t;

  typedef enum logic [8:0] {
    M_WELCOME = 9'b000000001,
    M_TIME    = 9'b000000010,
    M_MENU    = 9'b000000100,
    M_HOUR    = 9'b000001000,
    M_MINUTE  = 9'b000010000,
    M_ZONE    = 9'b000100000,
    M_VIEW    = 9'b001000000,
    M_RINGING = 9'b010000000,
    M_CONFIRM = 9'b100000000
  } mode_t;

  // scalar menu and buzzer state
  typedef struct packed {
    mode_t                     mode;
    logic [1:0]                cursor;
    logic signed [ZONE_W-1:0]  zone;
    logic                      any_ring;
    logic [BEEP_W-1:0]         beep;
    logic                      buzz;
  } ctrl_t;

  // per-alarm operations decoded from the button event
  typedef struct packed {
    logic hour_up;
    logic hour_dn;
    logic min_up;
    logic min_dn;
    logic arm;
    logic del;
    logic stop_all;
    logic snooze;
    logic tick;
    logic check;
  } op_t;

  // state of one alarm
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic              armed;
    logic              ringing;
    logic              snoozed;
    logic              quiet;
    logic [SNZ_W-1:0]  count;
  } lane_st_t;

  function automatic logic [HOUR_W-1:0] hour_inc(input logic [HOUR_W-1:0] v);
    return (v >= HOUR_TOP) ? '0 : v + HOUR_W'(1);
  endfunction

  function automatic logic [HOUR_W-1:0] hour_dec(input logic [HOUR_W-1:0] v);
    return (v == '0 || v > HOUR_TOP) ? HOUR_TOP : v - HOUR_W'(1);
  endfunction

  function automatic logic [MIN_W-1:0] min_inc(input logic [MIN_W-1:0] v);
    return (v >= MIN_TOP) ? '0 : v + MIN_W'(1);
  endfunction

  function automatic logic [MIN_W-1:0] min_dec(input logic [MIN_W-1:0] v);
    return (v == '0 || v > MIN_TOP) ? MIN_TOP : v - MIN_W'(1);
  endfunction

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      M_WELCOME: c = MODE_W'(0);
      M_TIME:    c = MODE_W'(1);
      M_MENU:    c = MODE_W'(2);
      M_HOUR:    c = MODE_W'(3);
      M_MINUTE:  c = MODE_W'(4);
      M_ZONE:    c = MODE_W'(5);
      M_VIEW:    c = MODE_W'(6);
      M_RINGING: c = MODE_W'(7);
      M_CONFIRM: c = MODE_W'(8);
      default:   c = MODE_W'(0);
    endcase
    return c;
  endfunction

endpackage

// File: rtl/alm_ifs.sv
// alm_ifs: valid/ready channel interfaces for button events, results and configuration writes.
// Depends on alm_pkg for field widths.
interface alm_in_if import alm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [HOUR_W-1:0] hour_now;
  logic [MIN_W-1:0]  minute_now;

  modport source (output valid, command, hour_now, minute_now, input ready);
  modport sink   (input valid, command, hour_now, minute_now, output ready);
endinterface

interface alm_out_if import alm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        ui_mode;
  logic [1:0]               menu_index;
  logic                     edited_alarm;
  logic                     viewed_alarm;
  logic [HOUR_W-1:0]        shown_hour;
  logic [MIN_W-1:0]         shown_minute;
  logic signed [ZONE_W-1:0] zone_halfhours;
  logic [1:0]               active_mask;
  logic                     ringing_flag;
  logic                     buzzer_on;

  modport source (output valid, ui_mode, menu_index, edited_alarm, viewed_alarm, shown_hour,
                  shown_minute, zone_halfhours, active_mask, ringing_flag, buzzer_on,
                  input ready);
  modport sink   (input valid, ui_mode, menu_index, edited_alarm, viewed_alarm, shown_hour,
                  shown_minute, zone_halfhours, active_mask, ringing_flag, buzzer_on,
                  output ready);
endinterface

interface alm_cfg_if import alm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CFG_A_W-1:0] addr;
  logic [CFG_D_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

// File: rtl/alarm_clock_menu_controller_core.sv
// Alarm clock menu controller, top level: state registers, result register, config registers.
// Depends on alm_pkg, alm_ifs, alm_menu and alm_lane.
// A result is registered: it appears in the cycle after its event beat is accepted.
// Throughput: one event per cycle; in_ch.ready drops only while a result waits on out_ch.ready.
// Reset (synchronous, rst_n low): welcome mode, zone 11, alarms cleared and unarmed,
// snooze 120000 ticks, beep phase 500 ticks; no result pending.
module alarm_clock_menu_controller_core import alm_pkg::*; #(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  alm_in_if.sink    in_ch,
  alm_out_if.source out_ch,
  alm_cfg_if.sink   cfg_ch
);

  localparam int SEL_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

  ctrl_t             ctrl_r, ctrl_mid, ctrl_nxt;
  logic [SEL_W-1:0]  edit_r, edit_mid, edit_nxt;
  logic [SEL_W-1:0]  view_r, view_nxt;
  lane_st_t          lane_r   [NUM_ALARMS];
  lane_st_t          lane_nxt [NUM_ALARMS];
  logic [NUM_ALARMS-1:0] start_v, is_edit, is_view, armed_v, ring_v, ring_nxt_v, snz_v;
  logic [SNZ_W-1:0]  snooze_ticks_r;
  logic [BEEP_W-1:0] beep_half_r;
  op_t               op;
  logic              in_acc;
  logic              out_valid_r;
  logic [SEL_W-1:0]  first_ring;
  logic [1:0]        mask_nxt;

  assign in_ch.ready  = ~out_valid_r | out_ch.ready;
  assign in_acc       = in_ch.valid & in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  alm_menu #(.NUM_ALARMS(NUM_ALARMS)) u_menu (
    .command    (in_ch.command),
    .cur        (ctrl_r),
    .edit_sel   (edit_r),
    .view_sel   (view_r),
    .view_armed (armed_v[view_r]),
    .beep_half  (beep_half_r),
    .nxt        (ctrl_mid),
    .edit_nxt   (edit_mid),
    .view_nxt   (view_nxt),
    .op         (op)
  );

  for (genvar g = 0; g < NUM_ALARMS; g++) begin : g_lane
    assign is_edit[g]    = (edit_r == SEL_W'(g));
    assign is_view[g]    = (view_r == SEL_W'(g));
    assign armed_v[g]    = lane_r[g].armed;
    assign ring_v[g]     = lane_r[g].ringing;
    assign snz_v[g]      = lane_r[g].snoozed;
    assign ring_nxt_v[g] = lane_nxt[g].ringing;

    alm_lane u_lane (
      .cur          (lane_r[g]),
      .op           (op),
      .is_edit      (is_edit[g]),
      .is_view      (is_view[g]),
      .hour_now     (in_ch.hour_now),
      .minute_now   (in_ch.minute_now),
      .snooze_ticks (snooze_ticks_r),
      .nxt          (lane_nxt[g]),
      .start        (start_v[g])
    );
  end

  // lowest-numbered ringing alarm becomes the edited one
  always_comb begin
    first_ring = '0;
    for (int i = NUM_ALARMS - 1; i >= 0; i--) begin
      if (ring_nxt_v[i]) first_ring = SEL_W'(i);
    end
  end

  always_comb begin
    ctrl_nxt = ctrl_mid;
    edit_nxt = edit_mid;
    if (|start_v) begin
      ctrl_nxt.any_ring = 1'b1;
      ctrl_nxt.mode     = M_RINGING;
      ctrl_nxt.buzz     = 1'b1;
      ctrl_nxt.beep     = '0;
      edit_nxt          = first_ring;
    end
  end

  assign mask_nxt[0] = lane_nxt[0].armed;
  if (NUM_ALARMS > 1) begin : g_mask2
    assign mask_nxt[1] = lane_nxt[1].armed;
  end else begin : g_mask1
    assign mask_nxt[1] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.mode     <= M_WELCOME;
      ctrl_r.cursor   <= '0;
      ctrl_r.zone     <= ZONE_RST;
      ctrl_r.any_ring <= 1'b0;
      ctrl_r.beep     <= '0;
      ctrl_r.buzz     <= 1'b0;
      edit_r          <= '0;
      view_r          <= '0;
      for (int i = 0; i < NUM_ALARMS; i++) lane_r[i] <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        ctrl_r <= ctrl_nxt;
        edit_r <= edit_nxt;
        view_r <= view_nxt;
        for (int i = 0; i < NUM_ALARMS; i++) lane_r[i] <= lane_nxt[i];
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snooze_ticks_r <= SNOOZE_RST;
      beep_half_r    <= BEEP_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_reg_t'(cfg_ch.addr))
        CFG_SNOOZE: snooze_ticks_r <= cfg_ch.wdata[SNZ_W-1:0];
        CFG_BEEP:   beep_half_r    <= cfg_ch.wdata[BEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // result beat register
  logic [MODE_W-1:0]        ui_mode_r;
  logic [1:0]               menu_index_r;
  logic                     edited_r;
  logic                     viewed_r;
  logic [HOUR_W-1:0]        shown_hour_r;
  logic [MIN_W-1:0]         shown_minute_r;
  logic signed [ZONE_W-1:0] zone_out_r;
  logic [1:0]               mask_r;
  logic                     ringing_r;
  logic                     buzzer_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ui_mode_r      <= mode_code(ctrl_nxt.mode);
      menu_index_r   <= ctrl_nxt.cursor;
      edited_r       <= edit_nxt[0];
      viewed_r       <= view_nxt[0];
      shown_hour_r   <= lane_nxt[edit_nxt].hour;
      shown_minute_r <= lane_nxt[edit_nxt].minute;
      zone_out_r     <= ctrl_nxt.zone;
      mask_r         <= mask_nxt;
      ringing_r      <= ctrl_nxt.any_ring;
      buzzer_r       <= ctrl_nxt.buzz;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ui_mode        = ui_mode_r;
  assign out_ch.menu_index     = menu_index_r;
  assign out_ch.edited_alarm   = edited_r;
  assign out_ch.viewed_alarm   = viewed_r;
  assign out_ch.shown_hour     = shown_hour_r;
  assign out_ch.shown_minute   = shown_minute_r;
  assign out_ch.zone_halfhours = zone_out_r;
  assign out_ch.active_mask    = mask_r;
  assign out_ch.ringing_flag   = ringing_r;
  assign out_ch.buzzer_on      = buzzer_r;

  a_ring_mode: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl_r.any_ring == (ctrl_r.mode == M_RINGING))
    else $error("ringing flag and ringing mode disagree");

  a_buzz_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl_r.any_ring |-> !ctrl_r.buzz)
    else $error("buzzer driven while nothing rings");

  a_snz_ring: assert property (@(posedge clk) disable iff (!rst_n)
    (ring_v & snz_v) == '0)
    else $error("alarm both snoozed and ringing");

  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(edit_r) < NUM_ALARMS) && (int'(view_r) < NUM_ALARMS))
    else $error("alarm select out of range");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted event produced no result");

endmodule

// File: rtl/alm_lane.sv
// alm_lane: next state of one alarm: edits, delete, stop, snooze, snooze tick count and match.
// Depends on alm_pkg.
module alm_lane import alm_pkg::*; (
  input  lane_st_t          cur,
  input  op_t               op,
  input  logic              is_edit,
  input  logic              is_view,
  input  logic [HOUR_W-1:0] hour_now,
  input  logic [MIN_W-1:0]  minute_now,
  input  logic [SNZ_W-1:0]  snooze_ticks,
  output lane_st_t          nxt,
  output logic              start
);

  always_comb begin
    lane_st_t s;
    logic     due;
    s     = cur;
    due   = 1'b1;
    start = 1'b0;

    if (is_edit) begin
      if (op.hour_up) s.hour   = hour_inc(s.hour);
      if (op.hour_dn) s.hour   = hour_dec(s.hour);
      if (op.min_up)  s.minute = min_inc(s.minute);
      if (op.min_dn)  s.minute = min_dec(s.minute);
      if (op.arm)     s.armed  = 1'b1;
      if (op.snooze) begin
        s.ringing = 1'b0;
        s.snoozed = 1'b1;
        s.count   = '0;
      end
    end
    if (is_view && op.del) begin
      s.armed   = 1'b0;
      s.ringing = 1'b0;
      s.snoozed = 1'b0;
    end
    if (op.stop_all) begin
      s.quiet   = s.quiet | s.ringing;
      s.ringing = 1'b0;
      s.snoozed = 1'b0;
    end

    if (op.tick && s.snoozed && s.count != SNZ_MAX) s.count = s.count + SNZ_W'(1);

    // a stopped alarm stays quiet until the clock leaves its minute
    if (s.hour != hour_now || s.minute != minute_now) s.quiet = 1'b0;

    if (op.check) begin
      if (s.snoozed) begin
        if (s.count < snooze_ticks) begin
          due = 1'b0;
        end else begin
          s.snoozed = 1'b0;
          s.hour    = hour_now;
          s.minute  = minute_now;
        end
      end
      if (due && s.armed && !s.ringing && !s.quiet &&
          s.hour == hour_now && s.minute == minute_now) begin
        s.ringing = 1'b1;
        start     = 1'b1;
      end
    end
    nxt = s;
  end

endmodule

// File: rtl/alm_menu.sv
// alm_menu: button decode for the nine-mode menu, zone offset, cursor and buzzer timing.
// Depends on alm_pkg; produces the per-alarm operations consumed by alm_lane.
module alm_menu import alm_pkg::*; #(
  parameter int NUM_ALARMS = NUM_ALARMS_DEF,
  localparam int SEL_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1
) (
  input  logic [CMD_W-1:0]  command,
  input  ctrl_t             cur,
  input  logic [SEL_W-1:0]  edit_sel,
  input  logic [SEL_W-1:0]  view_sel,
  input  logic              view_armed,
  input  logic [BEEP_W-1:0] beep_half,
  output ctrl_t             nxt,
  output logic [SEL_W-1:0]  edit_nxt,
  output logic [SEL_W-1:0]  view_nxt,
  output op_t               op
);

  localparam logic [SEL_W-1:0] LAST = SEL_W'(NUM_ALARMS - 1);
  localparam logic [SEL_W-1:0] SECOND = (NUM_ALARMS > 1) ? SEL_W'(1) : '0;

  always_comb begin
    ctrl_t                  c;
    logic signed [ZONE_W:0] zs;
    logic [BEEP_W:0]        bsum;
    c        = cur;
    edit_nxt = edit_sel;
    view_nxt = view_sel;
    op       = '0;
    zs       = {cur.zone[ZONE_W-1], cur.zone};
    bsum     = {1'b0, cur.beep} + (BEEP_W+1)'(1);

    case (cmd_t'(command))
      CMD_RIGHT: begin
        case (cur.mode)
          M_WELCOME: c.mode = M_TIME;
          M_TIME: begin
            c.mode   = M_MENU;
            c.cursor = 2'd0;
          end
          M_MENU: begin
            case (cur.cursor)
              2'd0: begin
                edit_nxt = '0;
                c.mode   = M_HOUR;
              end
              2'd1: begin
                edit_nxt = SECOND;
                c.mode   = M_HOUR;
              end
              2'd2: c.mode = M_ZONE;
              default: begin
                view_nxt = '0;
                c.mode   = M_VIEW;
              end
            endcase
          end
          M_HOUR:   c.mode = M_MINUTE;
          M_MINUTE: begin
            op.arm = 1'b1;
            c.mode = M_MENU;
          end
          M_ZONE:   c.mode = M_MENU;
          M_VIEW:   if (view_armed) c.mode = M_CONFIRM;
          M_CONFIRM: begin
            op.del = 1'b1;
            c.mode = M_VIEW;
          end
          M_RINGING: begin
            op.stop_all = 1'b1;
            c.any_ring  = 1'b0;
            c.buzz      = 1'b0;
            c.beep      = '0;
            c.mode      = M_TIME;
          end
          default: ;
        endcase
      end
      CMD_LEFT: begin
        case (cur.mode)
          M_TIME:                     c.mode = M_WELCOME;
          M_MENU, M_VIEW, M_CONFIRM:  c.mode = M_TIME;
          M_HOUR, M_MINUTE, M_ZONE:   c.mode = M_MENU;
          default: ;
        endcase
      end
      CMD_UP: begin
        case (cur.mode)
          M_HOUR:   op.hour_up = 1'b1;
          M_MINUTE: op.min_up  = 1'b1;
          M_ZONE: begin
            zs = zs + (ZONE_W+1)'(1);
            if (zs > (ZONE_W+1)'(ZONE_LIM)) zs = zs - (ZONE_W+1)'(ZONE_LIM);
            c.zone = zs[ZONE_W-1:0];
          end
          M_MENU:   c.cursor = cur.cursor - 2'd1;
          M_VIEW:   view_nxt = (view_sel == '0) ? LAST : view_sel - SEL_W'(1);
          M_CONFIRM: begin
            op.del = 1'b1;
            c.mode = M_VIEW;
          end
          default: ;
        endcase
      end
      CMD_DOWN: begin
        case (cur.mode)
          M_HOUR:   op.hour_dn = 1'b1;
          M_MINUTE: op.min_dn  = 1'b1;
          M_ZONE: begin
            zs = zs - (ZONE_W+1)'(1);
            if (zs < -(ZONE_W+1)'(ZONE_LIM)) zs = zs + (ZONE_W+1)'(ZONE_LIM);
            c.zone = zs[ZONE_W-1:0];
          end
          M_MENU:    c.cursor = cur.cursor + 2'd1;
          M_VIEW:    view_nxt = (view_sel == LAST) ? '0 : view_sel + SEL_W'(1);
          M_CONFIRM: c.mode = M_VIEW;
          M_RINGING: begin
            op.snooze  = 1'b1;
            c.any_ring = 1'b0;
            c.buzz     = 1'b0;
            c.beep     = '0;
            c.mode     = M_TIME;
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        op.tick = 1'b1;
        if (cur.any_ring) begin
          if (bsum >= {1'b0, beep_half}) begin
            c.buzz = ~cur.buzz;
            c.beep = '0;
          end else begin
            c.beep = bsum[BEEP_W-1:0];
          end
        end
      end
      default: ;
    endcase

    // new alarms are only picked up while nothing rings
    op.check = ~c.any_ring;
    nxt      = c;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for alarm_clock_menu_controller_core (button/tick beats in, UI state out).
// Depends on alm_pkg and the channel interfaces in alm_ifs; predicts every result in-bench.
module tb_top;
  import alm_pkg::*;

  localparam int N_ALARMS    = NUM_ALARMS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 235;
  localparam int PRINT_CAP   = 50;

  localparam logic [1:0] ENTRY_ALARM0 = 2'd0;
  localparam logic [1:0] ENTRY_ALARM1 = 2'd1;
  localparam logic [1:0] ENTRY_ZONE   = 2'd2;
  localparam logic [1:0] ENTRY_VIEW   = 2'd3;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  typedef enum logic [MODE_W-1:0] {
    UI_WELCOME, UI_TIME, UI_MENU, UI_HOUR, UI_MINUTE, UI_ZONE, UI_VIEW, UI_RINGING, UI_CONFIRM
  } ui_mode_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
  } button_evt_t;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [1:0]               cursor;
    logic                     edit;
    logic                     view;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic signed [ZONE_W-1:0] zone;
    logic [1:0]               mask;
    logic                     ring;
    logic                     buzz;
  } reading_t;

  typedef struct packed {
    ui_mode_t                        mode;
    logic [1:0]                      cursor;
    logic                            edit;
    logic                            view;
    int                              zone;
    logic [N_ALARMS-1:0][HOUR_W-1:0] hr;
    logic [N_ALARMS-1:0][MIN_W-1:0]  mn;
    logic [N_ALARMS-1:0]             armed;
    logic [N_ALARMS-1:0]             ringing;
    logic [N_ALARMS-1:0]             snoozed;
    logic [N_ALARMS-1:0]             quiet;
    logic [N_ALARMS-1:0][SNZ_W-1:0]  cnt;
    logic                            ring;
    logic [BEEP_W-1:0]               beep;
    logic                            buzz;
    logic [SNZ_W-1:0]                snooze_ticks;
    logic [BEEP_W-1:0]               beep_half;
  } clock_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  alm_in_if  in_bus();
  alm_out_if out_bus();
  alm_cfg_if cfg_bus();

  logic               drv_valid = 1'b0;
  logic [CMD_W-1:0]   drv_cmd = '0;
  logic [HOUR_W-1:0]  drv_hour = '0;
  logic [MIN_W-1:0]   drv_min = '0;
  logic               sink_ready = 1'b0;
  logic               cfg_valid_q = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr_q = '0;
  logic [CFG_D_W-1:0] cfg_data_q = '0;

  assign in_bus.valid      = drv_valid;
  assign in_bus.command    = drv_cmd;
  assign in_bus.hour_now   = drv_hour;
  assign in_bus.minute_now = drv_min;
  assign out_bus.ready     = sink_ready;
  assign cfg_bus.valid     = cfg_valid_q;
  assign cfg_bus.addr      = cfg_addr_q;
  assign cfg_bus.wdata     = cfg_data_q;

  alarm_clock_menu_controller_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  button_evt_t  pending_beats[$];
  reading_t     expected_readings[$];
  clock_state_t gen_st;
  clock_state_t chk_st;
  button_evt_t  next_beat;
  reading_t     seen;
  reading_t     want;
  int           send_gap_pct = 0;
  int           stall_pct = 0;
  int           fail_count = 0;
  int           cycle_count = 0;
  int           beats_made = 0;
  int           wall_h = 0;
  int           wall_m = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic clock_state_t power_on_state();
    clock_state_t s;
    s = '0;
    s.mode = UI_WELCOME;
    s.zone = 11;
    s.snooze_ticks = SNZ_W'(120000);
    s.beep_half = BEEP_W'(500);
    return s;
  endfunction

  function automatic void clear_viewed(inout clock_state_t s);
    s.armed[s.view] = 1'b0;
    s.ringing[s.view] = 1'b0;
    s.snoozed[s.view] = 1'b0;
    s.mode = UI_VIEW;
  endfunction

  function automatic void hush(inout clock_state_t s);
    s.ring = 1'b0;
    s.buzz = 1'b0;
    s.beep = '0;
    s.mode = UI_TIME;
  endfunction

  // One beat: button first, then tick work, quiet release, then ring start.
  function automatic reading_t advance_clock(inout clock_state_t s, input button_evt_t ev);
    reading_t r;
    logic     e;
    logic     started;
    int       b;
    e = s.edit;
    started = 1'b0;
    case (ev.command)
      CMD_RIGHT: begin
        case (s.mode)
          UI_WELCOME: s.mode = UI_TIME;
          UI_TIME: begin
            s.mode = UI_MENU;
            s.cursor = ENTRY_ALARM0;
          end
          UI_MENU: begin
            case (s.cursor)
              ENTRY_ALARM0: begin
                s.edit = 1'b0;
                s.mode = UI_HOUR;
              end
              ENTRY_ALARM1: begin
                s.edit = 1'b1;
                s.mode = UI_HOUR;
              end
              ENTRY_ZONE: s.mode = UI_ZONE;
              default: begin
                s.view = 1'b0;
                s.mode = UI_VIEW;
              end
            endcase
          end
          UI_HOUR: s.mode = UI_MINUTE;
          UI_MINUTE: begin
            s.armed[s.edit] = 1'b1;
            s.mode = UI_MENU;
          end
          UI_ZONE: s.mode = UI_MENU;
          UI_VIEW: if (s.armed[s.view]) s.mode = UI_CONFIRM;
          UI_CONFIRM: clear_viewed(s);
          UI_RINGING: begin
            s.quiet |= s.ringing;
            s.ringing = '0;
            s.snoozed = '0;
            hush(s);
          end
          default: ;
        endcase
      end
      CMD_LEFT: begin
        case (s.mode)
          UI_TIME: s.mode = UI_WELCOME;
          UI_MENU, UI_VIEW, UI_CONFIRM: s.mode = UI_TIME;
          UI_HOUR, UI_MINUTE, UI_ZONE: s.mode = UI_MENU;
          default: ;
        endcase
      end
      CMD_UP: begin
        case (s.mode)
          UI_HOUR: s.hr[e] = (s.hr[e] >= HOUR_TOP) ? '0 : s.hr[e] + 1'b1;
          UI_MINUTE: s.mn[e] = (s.mn[e] >= MIN_TOP) ? '0 : s.mn[e] + 1'b1;
          UI_ZONE: begin
            s.zone = s.zone + 1;
            if (s.zone > ZONE_LIM) s.zone = s.zone - ZONE_LIM;
          end
          UI_MENU: s.cursor = s.cursor - 1'b1;
          UI_VIEW: s.view = ~s.view;
          UI_CONFIRM: clear_viewed(s);
          default: ;
        endcase
      end
      CMD_DOWN: begin
        case (s.mode)
          UI_HOUR: s.hr[e] = (s.hr[e] == '0 || s.hr[e] > HOUR_TOP) ? HOUR_TOP : s.hr[e] - 1'b1;
          UI_MINUTE: s.mn[e] = (s.mn[e] == '0 || s.mn[e] > MIN_TOP) ? MIN_TOP : s.mn[e] - 1'b1;
          UI_ZONE: begin
            s.zone = s.zone - 1;
            if (s.zone < -ZONE_LIM) s.zone = s.zone + ZONE_LIM;
          end
          UI_MENU: s.cursor = s.cursor + 1'b1;
          UI_VIEW: s.view = ~s.view;
          UI_CONFIRM: s.mode = UI_VIEW;
          UI_RINGING: begin
            s.ringing[e] = 1'b0;
            s.snoozed[e] = 1'b1;
            s.cnt[e] = '0;
            hush(s);
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        for (int i = 0; i < N_ALARMS; i++)
          if (s.snoozed[i] && s.cnt[i] != SNZ_MAX) s.cnt[i] = s.cnt[i] + 1'b1;
        if (s.ring) begin
          b = int'(s.beep) + 1;
          if (b >= int'(s.beep_half)) begin
            s.buzz = ~s.buzz;
            s.beep = '0;
          end else begin
            s.beep = BEEP_W'(b);
          end
        end
      end
      default: ;
    endcase

    for (int i = 0; i < N_ALARMS; i++)
      if (s.hr[i] != ev.hour || s.mn[i] != ev.minute) s.quiet[i] = 1'b0;

    if (!s.ring) begin
      for (int i = 0; i < N_ALARMS; i++) begin
        // a snoozed alarm still counting is skipped entirely
        if (!(s.snoozed[i] && s.cnt[i] < s.snooze_ticks)) begin
          if (s.snoozed[i]) begin
            s.snoozed[i] = 1'b0;
            s.hr[i] = ev.hour;
            s.mn[i] = ev.minute;
          end
          if (s.armed[i] && !s.ringing[i] && !s.quiet[i] &&
              s.hr[i] == ev.hour && s.mn[i] == ev.minute) begin
            s.ringing[i] = 1'b1;
            started = 1'b1;
          end
        end
      end
      if (started) begin
        s.ring = 1'b1;
        s.mode = UI_RINGING;
        s.buzz = 1'b1;
        s.beep = '0;
        s.edit = s.ringing[0] ? 1'b0 : 1'b1;
      end
    end

    r.mode = s.mode;
    r.cursor = s.cursor;
    r.edit = s.edit;
    r.view = s.view;
    r.hour = s.hr[s.edit];
    r.minute = s.mn[s.edit];
    r.zone = ZONE_W'(s.zone);
    r.mask = s.armed;
    r.ring = s.ring;
    r.buzz = s.buzz;
    return r;
  endfunction

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else if (!drv_valid || in_bus.ready) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_beat = pending_beats.pop_front();
        drv_valid <= 1'b1;
        drv_cmd <= next_beat.command;
        drv_hour <= next_beat.hour;
        drv_min <= next_beat.minute;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sink_ready <= ($urandom_range(99) >= stall_pct);
  end

  // monitor: predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        expected_readings.push_back(advance_clock(chk_st,
          {in_bus.command, in_bus.hour_now, in_bus.minute_now}));
      if (out_bus.valid && out_bus.ready) begin
        seen.mode = out_bus.ui_mode;
        seen.cursor = out_bus.menu_index;
        seen.edit = out_bus.edited_alarm;
        seen.view = out_bus.viewed_alarm;
        seen.hour = out_bus.shown_hour;
        seen.minute = out_bus.shown_minute;
        seen.zone = out_bus.zone_halfhours;
        seen.mask = out_bus.active_mask;
        seen.ring = out_bus.ringing_flag;
        seen.buzz = out_bus.buzzer_on;
        if (expected_readings.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_readings.pop_front();
          if (seen.mode !== want.mode)
            report($sformatf("ui_mode %0d, expected %0d", seen.mode, want.mode));
          if (seen.cursor !== want.cursor)
            report($sformatf("menu_index %0d, expected %0d", seen.cursor, want.cursor));
          if (seen.edit !== want.edit)
            report($sformatf("edited_alarm %0d, expected %0d", seen.edit, want.edit));
          if (seen.view !== want.view)
            report($sformatf("viewed_alarm %0d, expected %0d", seen.view, want.view));
          if (seen.hour !== want.hour)
            report($sformatf("shown_hour %0d, expected %0d", seen.hour, want.hour));
          if (seen.minute !== want.minute)
            report($sformatf("shown_minute %0d, expected %0d", seen.minute, want.minute));
          if (seen.zone !== want.zone)
            report($sformatf("zone_halfhours %0d, expected %0d", seen.zone, want.zone));
          if (seen.mask !== want.mask)
            report($sformatf("active_mask %0d, expected %0d", seen.mask, want.mask));
          if (seen.ring !== want.ring)
            report($sformatf("ringing_flag %0d, expected %0d", seen.ring, want.ring));
          if (seen.buzz !== want.buzz)
            report($sformatf("buzzer_on %0d, expected %0d", seen.buzz, want.buzz));
        end
      end
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_D_W-1:0] val);
    @(posedge clk);
    cfg_valid_q <= 1'b1;
    cfg_addr_q <= idx;
    cfg_data_q <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_valid_q <= 1'b0;
    if (idx == CFG_SNOOZE) begin
      gen_st.snooze_ticks = val;
      chk_st.snooze_ticks = val;
    end else begin
      gen_st.beep_half = val[BEEP_W-1:0];
      chk_st.beep_half = val[BEEP_W-1:0];
    end
  endtask

  // look between edges so the driver and monitor updates of the last edge are visible
  task automatic drain();
    while (pending_beats.size() != 0 || expected_readings.size() != 0 || drv_valid)
      @(negedge clk);
  endtask

  // queue one beat; the generator's own state copy tracks where the menu will be
  task automatic emit_at(input logic [CMD_W-1:0] cmd, input logic [HOUR_W-1:0] h,
                         input logic [MIN_W-1:0] m);
    button_evt_t ev;
    ev.command = cmd;
    ev.hour = h;
    ev.minute = m;
    void'(advance_clock(gen_st, ev));
    pending_beats.push_back(ev);
    if (cmd <= CMD_DOWN) beats_made++;
    if ($urandom_range(99) < 4) begin
      wall_m = (wall_m + 1) % 60;
      if (wall_m == 0) wall_h = (wall_h + 1) % 24;
    end
  endtask

  // time mostly follows the wall clock or an alarm's stored time so rings happen
  task automatic emit(input logic [CMD_W-1:0] cmd);
    int                roll;
    int                k;
    logic [HOUR_W-1:0] h;
    logic [MIN_W-1:0]  m;
    roll = $urandom_range(99);
    k = $urandom_range(N_ALARMS - 1);
    if (roll < 50) begin
      h = HOUR_W'(wall_h);
      m = MIN_W'(wall_m);
    end else if (roll < 75) begin
      h = gen_st.hr[k];
      m = gen_st.mn[k];
    end else if (roll < 92) begin
      h = HOUR_W'($urandom_range(23));
      m = MIN_W'($urandom_range(59));
    end else begin
      h = HOUR_W'($urandom_range(31));
      m = MIN_W'($urandom_range(63));
    end
    emit_at(cmd, h, m);
  endtask

  task automatic goto_menu();
    int tries;
    tries = 0;
    while (gen_st.mode != UI_MENU && tries < 12) begin
      case (gen_st.mode)
        UI_WELCOME, UI_TIME, UI_RINGING: emit(CMD_RIGHT);
        default: emit(CMD_LEFT);
      endcase
      tries++;
    end
  endtask

  task automatic set_cursor(input logic [1:0] target);
    int tries;
    tries = 0;
    while (gen_st.mode == UI_MENU && gen_st.cursor != target && tries < 6) begin
      emit($urandom_range(1) ? CMD_DOWN : CMD_UP);
      tries++;
    end
    if (gen_st.mode == UI_MENU) emit(CMD_RIGHT);
  endtask

  task automatic run_sequence();
    int   pick;
    int   k;
    int   n;
    logic [CMD_W-1:0] dir;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // set an alarm: menu, entry, hour edits, minute edits, arm
      goto_menu();
      set_cursor($urandom_range(1) ? ENTRY_ALARM1 : ENTRY_ALARM0);
      repeat ($urandom_range(4)) emit($urandom_range(1) ? CMD_UP : CMD_DOWN);
      emit(CMD_RIGHT);
      repeat ($urandom_range(4)) emit($urandom_range(1) ? CMD_UP : CMD_DOWN);
      emit(CMD_RIGHT);
    end else if (pick < 45) begin
      if (gen_st.armed == '0) begin
        repeat ($urandom_range(3, 8)) emit(CMD_TICK);
      end else begin
        k = gen_st.armed[0] ? (gen_st.armed[1] ? $urandom_range(1) : 0) : 1;
        repeat ($urandom_range(1, 3)) emit_at(CMD_TICK, gen_st.hr[k], gen_st.mn[k]);
        repeat ($urandom_range(6)) emit(CMD_TICK);
        case ($urandom_range(3))
          0: begin
            emit_at(CMD_RIGHT, gen_st.hr[k], gen_st.mn[k]);
            repeat (2) emit_at(CMD_TICK, gen_st.hr[k], gen_st.mn[k]);
          end
          1: begin
            emit(CMD_DOWN);
            n = (gen_st.snooze_ticks <= 40) ? int'(gen_st.snooze_ticks) + 2 : 6;
            repeat (n) emit(CMD_TICK);
          end
          2: emit($urandom_range(1) ? CMD_LEFT : CMD_UP);
          default: repeat ($urandom_range(2, 10)) emit(CMD_TICK);
        endcase
      end
    end else if (pick < 50) begin
      // long zone sweep to cross the wrap in either direction
      goto_menu();
      set_cursor(ENTRY_ZONE);
      dir = $urandom_range(1) ? CMD_UP : CMD_DOWN;
      repeat ($urandom_range(30, 60)) emit_at(dir, HOUR_W'(wall_h), MIN_W'(wall_m));
      emit(CMD_LEFT);
    end else if (pick < 65) begin
      goto_menu();
      set_cursor(ENTRY_VIEW);
      if ($urandom_range(1)) emit($urandom_range(1) ? CMD_UP : CMD_DOWN);
      emit(CMD_RIGHT);
      case ($urandom_range(3))
        0: emit(CMD_RIGHT);
        1: emit(CMD_UP);
        2: emit(CMD_DOWN);
        default: emit(CMD_LEFT);
      endcase
    end else if (pick < 80) begin
      repeat ($urandom_range(5, 20)) emit(CMD_TICK);
    end else begin
      // noise, spare codes included
      repeat ($urandom_range(3, 10))
        emit_at(CMD_W'($urandom_range(CMD_SPARE_LAST)), HOUR_W'($urandom_range(31)),
                MIN_W'($urandom_range(63)));
    end
  endtask

  initial begin
    gen_st = power_on_state();
    chk_st = power_on_state();
    wall_h = $urandom_range(23);
    wall_m = $urandom_range(59);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_SNOOZE, CFG_D_W'(2));
    write_reg(CFG_BEEP, CFG_D_W'(1));

    // directed: ignored buttons, menu walk, edit wraps, arm, ring, snooze, stop, odd times
    emit_at(CMD_TICK, '0, '0);
    emit_at(CMD_SPARE_FIRST, '0, '0);
    emit_at(CMD_LEFT, '0, '0);
    emit_at(CMD_UP, '0, '0);
    emit_at(CMD_DOWN, '0, '0);
    emit_at(CMD_RIGHT, '0, '0);
    emit_at(CMD_UP, '0, '0);
    emit_at(CMD_RIGHT, '0, '0);
    emit_at(CMD_UP, '0, '0);
    emit_at(CMD_DOWN, '0, '0);
    emit_at(CMD_RIGHT, '0, '0);
    emit_at(CMD_DOWN, '0, '0);
    emit_at(CMD_UP, '0, '0);
    emit_at(CMD_RIGHT, '0, '0);
    emit_at(CMD_DOWN, '0, '0);
    emit_at(CMD_UP, '0, '0);
    emit_at(CMD_RIGHT, '0, '0);
    emit_at(CMD_TICK, '0, '0);
    emit_at(CMD_LEFT, '0, '0);
    emit_at(CMD_UP, '0, '0);
    emit_at(CMD_DOWN, '0, '0);
    emit_at(CMD_TICK, 5'd30, 6'd62);
    emit_at(CMD_TICK, 5'd30, 6'd62);
    emit_at(CMD_RIGHT, 5'd30, 6'd62);
    emit_at(CMD_TICK, 5'd30, 6'd62);
    emit_at(CMD_SPARE_LAST, 5'd31, 6'd63);
    emit_at(CMD_RIGHT, 5'd31, 6'd63);
    emit_at(CMD_RIGHT, 5'd31, 6'd63);
    emit_at(CMD_DOWN, 5'd31, 6'd63);
    emit_at(CMD_RIGHT, 5'd31, 6'd63);
    emit_at(CMD_UP, 5'd31, 6'd63);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 54; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 54; end
        default: begin send_gap_pct = 25; stall_pct = 25; end
      endcase
      case (p)
        0: begin write_reg(CFG_SNOOZE, CFG_D_W'(3)); write_reg(CFG_BEEP, CFG_D_W'(2)); end
        1: begin write_reg(CFG_SNOOZE, '0); write_reg(CFG_BEEP, '0); end
        2: begin write_reg(CFG_SNOOZE, SNZ_MAX); write_reg(CFG_BEEP, CFG_D_W'(16'hFFFF)); end
        3: begin write_reg(CFG_SNOOZE, CFG_D_W'(1)); write_reg(CFG_BEEP, CFG_D_W'(1)); end
        4: begin write_reg(CFG_SNOOZE, SNOOZE_RST); write_reg(CFG_BEEP, CFG_D_W'(BEEP_RST)); end
        default: begin
          write_reg(CFG_SNOOZE, CFG_D_W'($urandom_range(1, 40)));
          write_reg(CFG_BEEP, CFG_D_W'($urandom_range(1, 10)));
        end
      endcase
      beats_made = 0;
      while (beats_made < PHASE_BEATS) run_sequence();
      drain();
    end

    repeat (4) @(posedge clk);
    if (expected_readings.size() != 0) report("results still expected at end of run");
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/alm_pkg.sv
rtl/alm_ifs.sv
rtl/alm_lane.sv
rtl/alm_menu.sv
rtl/alarm_clock_menu_controller_core.sv
bench/tb_top.sv
